// ----- rtl/audio_mixer_overwrite_fifo_macros.svh -----
`ifndef AUDIO_MIXER_OVERWRITE_FIFO_MACROS_SVH
`define AUDIO_MIXER_OVERWRITE_FIFO_MACROS_SVH

// property checked at every rising edge of clock, off while reset is high
`define AMOF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// a signal keeps its value in the cycle after cond
`define AMOF_ASSERT_HOLD(label, cond, sig, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> $stable(sig)) \
      else $error(msg);

`endif

// ----- rtl/amof_pkg.sv -----
package amof_pkg;

   localparam int RING_DEPTH = 8192;
   localparam int PTR_W      = $clog2(RING_DEPTH);
   localparam int COUNT_W    = PTR_W + 1;
   localparam int FILL_W     = 14;
   localparam int SAMPLE_W   = 8;
   localparam int NUM_CH     = 5;
   localparam int GAIN_W     = 8;
   localparam int SUM_W      = 11;
   localparam int PROD_W     = 20;
   localparam int OUT_W      = 16;

   localparam logic [GAIN_W-1:0]       GAIN_RESET = 8'd51;
   localparam logic [SAMPLE_W-1:0]     CENTRE     = 8'd128;
   localparam logic signed [OUT_W-1:0] SAT_HIGH   = 16'sh7fff;
   localparam logic signed [OUT_W-1:0] SAT_LOW    = 16'sh8000;

   typedef enum logic [1:0] {
      CMD_PUSH  = 2'd0,
      CMD_POP   = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_type;

   typedef struct packed {
      logic [1:0]          cmd;
      logic [SAMPLE_W-1:0] wave_a;
      logic [SAMPLE_W-1:0] wave_b;
      logic [SAMPLE_W-1:0] wave_c;
      logic [SAMPLE_W-1:0] wave_d;
      logic [SAMPLE_W-1:0] wave_e;
      logic [NUM_CH-1:0]   channel_present;
   } req_word_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic clear;
   } ring_op_type;

   typedef struct packed {
      logic              popped;
      logic              dropped;
      logic [FILL_W-1:0] fill_level;
   } ring_stat_type;

endpackage

// ----- rtl/amof_req_if.sv -----
interface amof_req_if;
   import amof_pkg::*;

   logic                valid;
   logic                ready;
   logic [1:0]          cmd;
   logic [SAMPLE_W-1:0] wave_a;
   logic [SAMPLE_W-1:0] wave_b;
   logic [SAMPLE_W-1:0] wave_c;
   logic [SAMPLE_W-1:0] wave_d;
   logic [SAMPLE_W-1:0] wave_e;
   logic [NUM_CH-1:0]   channel_present;

   modport source (
      output valid, cmd, wave_a, wave_b, wave_c, wave_d, wave_e, channel_present,
      input  ready
   );

   modport sink (
      input  valid, cmd, wave_a, wave_b, wave_c, wave_d, wave_e, channel_present,
      output ready
   );
endinterface

// ----- rtl/amof_rsp_if.sv -----
interface amof_rsp_if;
   import amof_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] sample_out;
   logic                    sample_valid;
   logic [FILL_W-1:0]       fill_level;
   logic                    dropped_oldest;
   logic                    clipped;

   modport source (
      output valid, sample_out, sample_valid, fill_level, dropped_oldest, clipped,
      input  ready
   );

   modport sink (
      input  valid, sample_out, sample_valid, fill_level, dropped_oldest, clipped,
      output ready
   );
endinterface

// ----- rtl/amof_mix.sv -----
module amof_mix (
   input  logic [amof_pkg::NUM_CH-1:0][amof_pkg::SAMPLE_W-1:0] waves,
   input  logic [amof_pkg::NUM_CH-1:0]                         channel_present,
   input  logic [amof_pkg::GAIN_W-1:0]                         mix_gain,
   output logic signed [amof_pkg::OUT_W-1:0]                   mixed,
   output logic                                                clipped
);
   import amof_pkg::*;

   logic signed [SUM_W-1:0]  sum;
   logic signed [GAIN_W:0]   gain_s;
   logic signed [PROD_W-1:0] prod;

   always_comb begin
      sum = '0;
      for (int i = 0; i < NUM_CH; i++) begin
         if (channel_present[i]) begin
            sum = sum + $signed(SUM_W'(waves[i]) - SUM_W'(CENTRE));
         end
      end
   end

   assign gain_s = $signed({1'b0, mix_gain});
   assign prod   = PROD_W'(sum) * PROD_W'(gain_s);

   always_comb begin
      clipped = 1'b1;
      if (prod > PROD_W'(SAT_HIGH)) begin
         mixed = SAT_HIGH;
      end else if (prod < PROD_W'(SAT_LOW)) begin
         mixed = SAT_LOW;
      end else begin
         mixed   = prod[OUT_W-1:0];
         clipped = 1'b0;
      end
   end
endmodule

// ----- rtl/amof_ring.sv -----
module amof_ring (
   input  logic                             clock,
   input  logic                             reset,
   input  amof_pkg::ring_op_type            op,
   input  logic signed [amof_pkg::OUT_W-1:0] wr_data,
   output amof_pkg::ring_stat_type          stat,
   output logic signed [amof_pkg::OUT_W-1:0] rd_data
);
   import amof_pkg::*;

   logic [OUT_W-1:0]   mem [RING_DEPTH];
   logic [OUT_W-1:0]   rd_data_ff;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               full, empty, do_read, dropped;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign full    = (count_ff == COUNT_W'(RING_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_read = op.pop && !empty;
   assign dropped = op.push && full;

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (op.clear) begin
         rd_ptr_in = '0;
         wr_ptr_in = '0;
         count_in  = '0;
      end else if (op.push) begin
         wr_ptr_in = next_ptr(wr_ptr_ff);
         // full ring: oldest word is overwritten, count stays put
         if (full) begin
            rd_ptr_in = next_ptr(rd_ptr_ff);
         end else begin
            count_in = count_ff + COUNT_W'(1);
         end
      end else if (do_read) begin
         rd_ptr_in = next_ptr(rd_ptr_ff);
         count_in  = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   // ring memory: written at wr_ptr on push, read at rd_ptr on a pop of a non-empty ring
   always_ff @(posedge clock) begin
      if (op.push) begin
         mem[wr_ptr_ff] <= wr_data;
      end
      if (do_read) begin
         rd_data_ff <= mem[rd_ptr_ff];
      end
   end

   assign rd_data         = $signed(rd_data_ff);
   assign stat.popped     = do_read;
   assign stat.dropped    = dropped;
   assign stat.fill_level = FILL_W'(count_in);
endmodule

// ----- rtl/audio_mixer_overwrite_fifo.sv -----
// channel  dir  handshake      payload
// req      in   valid/ready    cmd, wave_a..wave_e, channel_present
// rsp      out  valid/ready    sample_out, sample_valid, fill_level, dropped_oldest, clipped
// csr      in   csr_wr_en      csr_wr_data (mix_gain)
//
// one word per cycle sustained while rsp is not stalled; a taken word passes through the
// input register, then mix, ring update and one ring memory access into the result register
// synchronous reset clears the valid flags, pointers and count and sets mix_gain to 51;
// ring memory contents are kept
// a stalled result holds; req_ready drops only while both registers are full and rsp is stalled
module audio_mixer_overwrite_fifo (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [amof_pkg::GAIN_W-1:0] csr_wr_data,
   amof_req_if.sink                    req,
   amof_rsp_if.source                  rsp
);
   import amof_pkg::*;

   logic                    in_valid_ff, in_valid_in;
   req_word_type            in_word_ff;
   logic                    out_valid_ff, out_valid_in;
   logic                    out_popped_ff;
   logic                    out_dropped_ff;
   logic                    out_clipped_ff;
   logic [FILL_W-1:0]       out_fill_ff;
   logic [GAIN_W-1:0]       gain_ff;
   logic                    advance, req_take;
   ring_op_type             op;
   ring_stat_type           stat;
   logic signed [OUT_W-1:0] mixed, rd_data;
   logic                    mix_clipped;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;
   assign req_take  = req.valid && req.ready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp.ready);

   always_comb begin
      op = '0;
      unique case (cmd_type'(in_word_ff.cmd))
         CMD_PUSH:  op.push  = advance;
         CMD_POP:   op.pop   = advance;
         CMD_CLEAR: op.clear = advance;
         default:   op = '0;
      endcase
   end

   amof_mix u_mix (
      .waves           ({in_word_ff.wave_e, in_word_ff.wave_d, in_word_ff.wave_c,
                         in_word_ff.wave_b, in_word_ff.wave_a}),
      .channel_present (in_word_ff.channel_present),
      .mix_gain        (gain_ff),
      .mixed           (mixed),
      .clipped         (mix_clipped)
   );

   amof_ring u_ring (
      .clock   (clock),
      .reset   (reset),
      .op      (op),
      .wr_data (mixed),
      .stat    (stat),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         gain_ff      <= GAIN_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            gain_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff <= '{cmd: req.cmd, wave_a: req.wave_a, wave_b: req.wave_b,
                         wave_c: req.wave_c, wave_d: req.wave_d, wave_e: req.wave_e,
                         channel_present: req.channel_present};
      end
      if (advance) begin
         out_popped_ff  <= stat.popped;
         out_dropped_ff <= stat.dropped;
         out_clipped_ff <= op.push && mix_clipped;
         out_fill_ff    <= stat.fill_level;
      end
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.sample_out     = out_popped_ff ? rd_data : '0;
   assign rsp.sample_valid   = out_popped_ff;
   assign rsp.fill_level     = out_fill_ff;
   assign rsp.dropped_oldest = out_dropped_ff;
   assign rsp.clipped        = out_clipped_ff;
endmodule

// ----- rtl/amof_checker.sv -----
`include "audio_mixer_overwrite_fifo_macros.svh"

module amof_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [amof_pkg::OUT_W-1:0] rsp_sample_out,
   input logic                              rsp_sample_valid,
   input logic [amof_pkg::FILL_W-1:0]       rsp_fill_level,
   input logic                              rsp_dropped_oldest,
   input logic                              rsp_clipped
);
   import amof_pkg::*;

   // ring never reports more than its depth
   `AMOF_ASSERT(fill_bound_a, rsp_valid |-> (rsp_fill_level <= FILL_W'(RING_DEPTH)), "fill above depth")

   // a popped word carries no push flags
   `AMOF_ASSERT(pop_flags_a, (rsp_valid && rsp_sample_valid) |-> (!rsp_dropped_oldest && !rsp_clipped), "push flag on pop")

   `AMOF_ASSERT(no_word_zero_a, (rsp_valid && !rsp_sample_valid) |-> (rsp_sample_out == '0), "sample without pop")

   // dropping only happens on a full ring, which stays full
   `AMOF_ASSERT(drop_full_a, (rsp_valid && rsp_dropped_oldest) |-> (rsp_fill_level == FILL_W'(RING_DEPTH)), "drop below full")

   `AMOF_ASSERT_HOLD(stall_hold_a, rsp_valid && !rsp_ready, rsp_sample_out, "stalled sample changed")
endmodule

bind audio_mixer_overwrite_fifo amof_checker u_amof_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp.valid),
   .rsp_ready          (rsp.ready),
   .rsp_sample_out     (rsp.sample_out),
   .rsp_sample_valid   (rsp.sample_valid),
   .rsp_fill_level     (rsp.fill_level),
   .rsp_dropped_oldest (rsp.dropped_oldest),
   .rsp_clipped        (rsp.clipped)
);
